// File: hdl/pcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pcd_pkg;

	localparam int DEDUP_ENTRIES = 64;
	localparam int ALLOWLIST_ENTRIES = 31;
	localparam int LENGTH_BITS = 24;
	localparam int KEY_TABLE_SIZE = 31;
	localparam int ALLOW_COUNT = (ALLOWLIST_ENTRIES < KEY_TABLE_SIZE) ?
		ALLOWLIST_ENTRIES : KEY_TABLE_SIZE;

	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;
	localparam logic [15:0] WINDOW_RESET = 16'd100;
	localparam logic [LENGTH_BITS-1:0] COUNT_MAX = '1;

	localparam logic [23:0] ALLOW_KEYS [KEY_TABLE_SIZE] = '{
		24'h21e535, 24'h21be01, 24'h21a83c, 24'h219804, 24'h216dd4, 24'h5d2b15,
		24'h5dcc51, 24'h875408, 24'h878408, 24'h876185, 24'h0d9ee1, 24'h0dee25,
		24'h0d2711, 24'h0d7690, 24'h0d755d, 24'h3d16b6, 24'h52ee25, 24'h664cc2,
		24'h66da30, 24'h664569, 24'h79994b, 24'h03f7f5, 24'h035408, 24'ha12711,
		24'ha18a6a, 24'h466bb8, 24'h4b4569, 24'ha1b121, 24'haade02, 24'haa7a64,
		24'h052b66
	};

	localparam logic [2:0] REG_FORWARD_ALL = 3'd0;
	localparam logic [2:0] REG_WINDOW = 3'd4;

	typedef enum logic [2:0] {
		V_EMPTY,
		V_CONTROL,
		V_SHORT,
		V_NOT_ALLOWED,
		V_DUPLICATE,
		V_FORWARD
	} verdict_t;

	typedef struct packed {
		logic byte_en;
		logic capture;
		logic rd_en;
		logic finish;
		verdict_t verdict;
	} cmd_t;

	typedef struct packed {
		logic needs_scan;
		verdict_t pre_verdict;
		logic hit;
		logic out_pending;
	} status_t;

	function automatic logic key_allowed(input logic [23:0] k);
		logic found;
		found = 1'b0;
		for (int i = 0; i < ALLOW_COUNT; i++) begin
			if (ALLOW_KEYS[i] == k) found = 1'b1;
		end
		return found;
	endfunction

endpackage
`default_nettype wire

// File: hdl/pcd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pcd_ctrl #(
	parameter int DEDUP_ENTRIES = pcd_pkg::DEDUP_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic action,
	output logic in_stall,
	input  wire pcd_pkg::status_t status,
	output pcd_pkg::cmd_t cmd,
	output logic [$clog2(DEDUP_ENTRIES)-1:0] idx
);
	import pcd_pkg::*;

	localparam int IW = $clog2(DEDUP_ENTRIES);
	localparam logic [IW-1:0] LAST = IW'(DEDUP_ENTRIES - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	state_t state_q, state_d;
	logic [IW-1:0] idx_q, idx_d;
	logic acc;

	assign in_stall = (state_q != ST_IDLE) || (action && status.out_pending);
	assign acc = in_valid && !in_stall;
	assign idx = idx_q;

	always_comb begin
		state_d = state_q;
		idx_d = idx_q;
		cmd = '0;
		cmd.verdict = V_FORWARD;
		case (state_q)
			ST_IDLE: begin
				if (acc && !action) begin
					cmd.byte_en = 1'b1;
				end else if (acc && action) begin
					if (status.needs_scan) begin
						cmd.capture = 1'b1;
						idx_d = '0;
						state_d = ST_SCAN;
					end else begin
						cmd.finish = 1'b1;
						cmd.verdict = status.pre_verdict;
					end
				end
			end
			ST_SCAN: begin
				if (status.hit) begin
					cmd.finish = 1'b1;
					cmd.verdict = V_DUPLICATE;
					state_d = ST_IDLE;
				end else begin
					cmd.rd_en = 1'b1;
					if (idx_q == LAST) begin
						state_d = ST_DRAIN;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			ST_DRAIN: begin
				cmd.finish = 1'b1;
				cmd.verdict = status.hit ? V_DUPLICATE : V_FORWARD;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
		end else begin
			state_q <= state_d;
			idx_q <= idx_d;
		end
	end

	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> (state_q == ST_IDLE))
		else $error("finish did not return to idle");
	a_drain_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_IDLE))
		else $error("drain lasted more than one cycle");
	a_rd_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (state_q == ST_SCAN))
		else $error("table read outside scan");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !status.out_pending)
		else $error("result finished while output still held");

endmodule
`default_nettype wire

// File: hdl/pcd_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module pcd_dp #(
	parameter int DEDUP_ENTRIES = pcd_pkg::DEDUP_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pcd_pkg::cmd_t cmd,
	input  wire logic [$clog2(DEDUP_ENTRIES)-1:0] idx,
	input  wire logic [7:0] data_byte,
	input  wire logic [31:0] now_ms,
	input  wire logic forward_all,
	input  wire logic [15:0] window_ms,
	output pcd_pkg::status_t status,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [2:0] verdict,
	output logic [3:0] packet_type,
	output logic [23:0] routing_key,
	output logic [31:0] packet_hash,
	output logic [23:0] packet_bytes,
	output logic [31:0] declared_size
);
	import pcd_pkg::*;

	localparam int IW = $clog2(DEDUP_ENTRIES);
	localparam int EW = 24 + LENGTH_BITS + 32 + 32;

	logic [LENGTH_BITS-1:0] count_q;
	logic [7:0] first_q;
	logic [31:0] size_q;
	logic [23:0] key_q;
	logic [31:0] hash_q;
	logic [31:0] now_q;
	logic [IW-1:0] ptr_q;
	logic [DEDUP_ENTRIES-1:0] valid_q;
	logic [EW-1:0] mem [DEDUP_ENTRIES];
	logic [EW-1:0] ent_s1;
	logic vld_s1, cmp_s1;

	logic [2:0] hlen;
	logic [3:0] off;
	logic [31:0] hash_next;
	logic [1:0] shamt;
	logic [23:0] e_key;
	logic [LENGTH_BITS-1:0] e_len;
	logic [31:0] e_hash, e_ticks, age, decl_sum;
	logic is_short, is_data;

	assign hlen = {1'b0, first_q[1:0]} + 3'd1;
	assign off = {1'b0, hlen} + 4'd1;
	assign hash_next = 32'((hash_q ^ {24'd0, data_byte}) * FNV_PRIME);
	assign shamt = 2'(count_q[1:0] - 2'd1);
	assign is_short = count_q < LENGTH_BITS'(off + 4'd3);
	assign is_data = (first_q[7:4] == 4'd0) || (first_q[7:4] == 4'd4);
	assign decl_sum = size_q + {28'd0, off};

	assign {e_key, e_len, e_hash, e_ticks} = ent_s1;
	assign age = now_q - e_ticks;

	always_comb begin
		status = '0;
		status.pre_verdict = V_FORWARD;
		if (count_q == '0) begin
			status.pre_verdict = V_EMPTY;
		end else if (!is_data) begin
			status.pre_verdict = V_CONTROL;
		end else if (is_short) begin
			status.pre_verdict = V_SHORT;
		end else if (!key_allowed(key_q) && !forward_all) begin
			status.pre_verdict = V_NOT_ALLOWED;
		end else begin
			status.needs_scan = 1'b1;
		end
		status.hit = cmp_s1 && vld_s1 && (e_key == key_q) && (e_len == count_q)
			&& (e_hash == hash_q) && (age < {16'd0, window_ms});
		status.out_pending = out_valid && out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			first_q <= '0;
			size_q <= '0;
			key_q <= '0;
			hash_q <= FNV_BASIS;
			ptr_q <= '0;
			valid_q <= '0;
			vld_s1 <= 1'b0;
			cmp_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			cmp_s1 <= cmd.rd_en;
			if (cmd.rd_en) vld_s1 <= valid_q[idx];
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cmd.byte_en) begin
				hash_q <= hash_next;
				if (count_q == '0) begin
					first_q <= data_byte;
				end else begin
					if (count_q <= LENGTH_BITS'(hlen)) begin
						size_q <= size_q | ({24'd0, data_byte} << {shamt, 3'b000});
					end
					if (count_q >= LENGTH_BITS'(off) && count_q < LENGTH_BITS'(off + 4'd3)) begin
						key_q <= {key_q[15:0], data_byte};
					end
				end
				if (count_q != COUNT_MAX) count_q <= count_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid <= 1'b1;
				if (cmd.verdict == V_FORWARD) begin
					valid_q[ptr_q] <= 1'b1;
					ptr_q <= (ptr_q == IW'(DEDUP_ENTRIES - 1)) ? '0 : ptr_q + 1'b1;
				end
				count_q <= '0;
				first_q <= '0;
				size_q <= '0;
				key_q <= '0;
				hash_q <= FNV_BASIS;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) now_q <= now_ms;
		if (cmd.rd_en) ent_s1 <= mem[idx];
		if (cmd.finish && cmd.verdict == V_FORWARD) begin
			mem[ptr_q] <= {key_q, count_q, hash_q, now_q};
		end
		if (cmd.finish) begin
			verdict <= cmd.verdict;
			packet_type <= first_q[7:4];
			routing_key <= (cmd.verdict == V_NOT_ALLOWED || cmd.verdict == V_DUPLICATE
				|| cmd.verdict == V_FORWARD) ? key_q : 24'd0;
			packet_hash <= hash_q;
			packet_bytes <= 24'(count_q);
			if (cmd.verdict == V_FORWARD) begin
				declared_size <= (decl_sum == 32'd0) ? 32'(count_q) : decl_sum;
			end else begin
				declared_size <= 32'd0;
			end
		end
	end

endmodule
`default_nettype wire

// File: hdl/packet_classifier_with_dedup_unit.sv
// A packet byte is taken while the unit is idle and the next item may follow at once.
// An end marker whose verdict needs no table lookup yields its result in the cycle after it is taken.
// A duplicate check reads the table one entry per cycle and ends early on a hit; its result
// is registered after the hit or the last read, and the next item is taken once the unit is idle again.
// An end marker waits while an earlier result is held by the output stall.
// Reset clears all table valid bits at once, the packet state and the control registers.
`timescale 1ns / 1ps
`default_nettype none
module packet_classifier_with_dedup_unit #(
	parameter int DEDUP_ENTRIES = pcd_pkg::DEDUP_ENTRIES
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [2:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic action,
	input  wire logic [7:0] data_byte,
	input  wire logic [31:0] now_ms,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [2:0] verdict,
	output logic [3:0] packet_type,
	output logic [23:0] routing_key,
	output logic [31:0] packet_hash,
	output logic [23:0] packet_bytes,
	output logic [31:0] declared_size
);
	import pcd_pkg::*;

	logic forward_all_q;
	logic [15:0] window_q;
	cmd_t cmd;
	status_t status;
	logic [$clog2(DEDUP_ENTRIES)-1:0] idx;

	assign pready = 1'b1;
	assign prdata = ({paddr[2], 2'b00} == REG_WINDOW) ? {16'd0, window_q}
		: {31'd0, forward_all_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_all_q <= 1'b0;
			window_q <= WINDOW_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if ({paddr[2], 2'b00} == REG_FORWARD_ALL) forward_all_q <= pwdata[0];
			else window_q <= pwdata[15:0];
		end
	end

	pcd_ctrl #(.DEDUP_ENTRIES(DEDUP_ENTRIES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .action(action),
		.in_stall(in_stall), .status(status), .cmd(cmd), .idx(idx)
	);

	pcd_dp #(.DEDUP_ENTRIES(DEDUP_ENTRIES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .idx(idx), .data_byte(data_byte),
		.now_ms(now_ms), .forward_all(forward_all_q), .window_ms(window_q),
		.status(status), .out_valid(out_valid), .out_stall(out_stall),
		.verdict(verdict), .packet_type(packet_type), .routing_key(routing_key),
		.packet_hash(packet_hash), .packet_bytes(packet_bytes),
		.declared_size(declared_size)
	);

endmodule
`default_nettype wire
